/* rtl/swm_pkg.sv */
`default_nettype none

package swm_pkg;

  // Width and reset value of the window_size register.
  localparam int unsigned WsBits = 7;
  localparam logic [WsBits-1:0] WsReset = 7'd3;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic upd;   // an item is accepted in this cycle
    logic full;  // the window already holds window_size samples
  } swm_ctrl_t;

endpackage

`default_nettype wire

/* rtl/swm_in_if.sv */
`default_nettype none

interface swm_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

`default_nettype wire

/* rtl/swm_out_if.sv */
`default_nettype none

interface swm_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS:0]   median_x2;
  logic signed [SAMPLE_BITS-1:0] lower_middle;

  modport source (output valid, output median_x2, output lower_middle, input ready);
  modport sink   (input valid, input median_x2, input lower_middle, output ready);
endinterface

`default_nettype wire

/* rtl/swm_cell.sv */
`default_nettype none

module swm_cell
  import swm_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned SB  = 16,
  parameter int unsigned KW  = 7,
  parameter int unsigned TW  = 6
) (
  input  wire logic                 clk_i,
  input  wire swm_ctrl_t            ctrl_i,
  input  wire logic signed [SB-1:0] sample_i,
  input  wire logic [TW-1:0]        tag_new_i,
  input  wire logic [TW-1:0]        ptr_i,
  input  wire logic [KW-1:0]        fill_i,
  // Left neighbour (lower position).
  input  wire logic signed [SB-1:0] l_value_i,
  input  wire logic [TW-1:0]        l_tag_i,
  input  wire logic                 l_gt_i,
  input  wire logic                 l_be_i,
  // Right neighbour (higher position).
  input  wire logic signed [SB-1:0] r_value_i,
  input  wire logic [TW-1:0]        r_tag_i,
  input  wire logic                 r_gt_i,
  output logic signed [SB-1:0]      value_o,
  output logic [TW-1:0]             tag_o,
  output logic                      gt_o,
  output logic                      be_o
);

  logic signed [SB-1:0] value_q, value_d;
  logic [TW-1:0]        tag_q, tag_d;
  logic                 valid, gt, ev, be;
  logic signed [SB-1:0] lp_v, lm_v;
  logic [TW-1:0]        lp_t, lm_t;
  logic                 lp_g, lm_g;

  // An empty position counts as greater than any sample.
  assign valid = KW'(IDX) < fill_i;
  assign gt    = !valid || (value_q > sample_i);
  assign ev    = ctrl_i.full && valid && (tag_q == ptr_i);
  assign be    = l_be_i | ev;

  // Entry at this position, and at the one below, once the evicted entry is gone.
  assign lp_v = be ? r_value_i : value_q;
  assign lp_t = be ? r_tag_i : tag_q;
  assign lp_g = be ? r_gt_i : gt;
  assign lm_v = l_be_i ? value_q : l_value_i;
  assign lm_t = l_be_i ? tag_q : l_tag_i;
  assign lm_g = l_be_i ? gt : l_gt_i;

  always_comb begin
    value_d = value_q;
    tag_d   = tag_q;
    if (ctrl_i.upd) begin
      priority if (!lp_g) begin
        value_d = lp_v;
        tag_d   = lp_t;
      end else if (!lm_g) begin
        value_d = sample_i;
        tag_d   = tag_new_i;
      end else begin
        value_d = lm_v;
        tag_d   = lm_t;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    tag_q   <= tag_d;
  end

  assign value_o = value_q;
  assign tag_o   = tag_q;
  assign gt_o    = gt;
  assign be_o    = be;

endmodule

`default_nettype wire

/* rtl/sliding_window_median.sv */
`default_nettype none

// Sliding-window median filter. Each item carries a signed sample; the last
// window_size samples (1 to MAX_WINDOW, zero taken as 1, larger values
// saturated) are kept in ascending order in a row of MAX_WINDOW cells, each
// holding one sample and its ring slot tag. When an item is taken, all cells
// compare against the new sample and shift by one place towards or away
// from their neighbours at once, removing the oldest entry and inserting
// the new one. The result (twice the median and the lower middle element)
// is picked from the cells once the output register is free and held
// there, so one item per clock is sustained while the output side takes
// results. No result is given until the window is full. Setting start_req
// or writing window_size empties the window.
module sliding_window_median
  import swm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [WsBits-1:0] cfg_wdata_i,
  swm_in_if.sink                 in_i,
  swm_out_if.source              out_o
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned KW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned TW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [WsBits-1:0] ws_q;
  logic [KW-1:0]     fill_q, fill_d;
  logic [TW-1:0]     ptr_q, ptr_d;
  logic              pend_q, pend_d;
  logic              out_valid_q;
  logic signed [SB:0]   med_q;
  logic signed [SB-1:0] lo_q;

  logic [KW-1:0] k, f, lo_idx, hi_idx;
  logic          accept, clear, full, result, out_load;
  logic [TW-1:0] tag_new;
  swm_ctrl_t     ctrl;

  logic signed [SB-1:0] cv [MAX_WINDOW+1];
  logic [TW-1:0]        ct [MAX_WINDOW+1];
  logic                 cg [MAX_WINDOW+1];
  logic                 cb [MAX_WINDOW];
  logic signed [SB-1:0] lo_val, hi_val;

  always_comb begin
    priority if (ws_q == '0) begin
      k = KW'(1);
    end else if (int'(ws_q) > int'(MAX_WINDOW)) begin
      k = KW'(MAX_WINDOW);
    end else begin
      k = KW'(ws_q);
    end
  end

  assign lo_idx = (k - KW'(1)) >> 1;
  assign hi_idx = k >> 1;

  assign out_load = pend_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !pend_q || out_load;
  assign accept = in_i.valid && in_i.ready;

  assign clear   = in_i.start_req || (fill_q > k);
  assign f       = clear ? '0 : fill_q;
  assign full    = (f == k);
  assign tag_new = full ? ptr_q : f[TW-1:0];
  assign result  = full || ((f + KW'(1)) == k);

  assign ctrl.upd  = accept;
  assign ctrl.full = full;

  always_comb begin
    fill_d = fill_q;
    ptr_d  = ptr_q;
    pend_d = pend_q && !out_load;
    if (accept) begin
      if (full) begin
        ptr_d = (KW'(ptr_q) == (k - KW'(1))) ? '0 : ptr_q + TW'(1);
      end else begin
        fill_d = f + KW'(1);
        ptr_d  = '0;
      end
      pend_d = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q   <= WsReset;
      fill_q <= '0;
      ptr_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (cfg_we_i) begin
        ws_q   <= cfg_wdata_i;
        fill_q <= '0;
        ptr_q  <= '0;
      end else begin
        fill_q <= fill_d;
        ptr_q  <= ptr_d;
      end
    end
  end

  // Past the top of the row every position reads as empty.
  assign cv[MAX_WINDOW] = '0;
  assign ct[MAX_WINDOW] = '0;
  assign cg[MAX_WINDOW] = 1'b1;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SB-1:0] l_v;
    logic [TW-1:0]        l_t;
    logic                 l_g, l_b;
    if (i == 0) begin : g_first
      // Below the bottom the new sample always goes in.
      assign l_v = '0;
      assign l_t = '0;
      assign l_g = 1'b0;
      assign l_b = 1'b0;
    end else begin : g_rest
      assign l_v = cv[i-1];
      assign l_t = ct[i-1];
      assign l_g = cg[i-1];
      assign l_b = cb[i-1];
    end

    swm_cell #(
      .IDX (i),
      .SB  (SB),
      .KW  (KW),
      .TW  (TW)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .sample_i  (in_i.sample),
      .tag_new_i (tag_new),
      .ptr_i     (ptr_q),
      .fill_i    (f),
      .l_value_i (l_v),
      .l_tag_i   (l_t),
      .l_gt_i    (l_g),
      .l_be_i    (l_b),
      .r_value_i (cv[i+1]),
      .r_tag_i   (ct[i+1]),
      .r_gt_i    (cg[i+1]),
      .value_o   (cv[i]),
      .tag_o     (ct[i]),
      .gt_o      (cg[i]),
      .be_o      (cb[i])
    );
  end

  // For an odd window both middle positions are the same cell.
  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (KW'(i) == lo_idx) lo_val = lo_val | cv[i];
      if (KW'(i) == hi_idx) hi_val = hi_val | cv[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      med_q <= (SB+1)'(lo_val) + (SB+1)'(hi_val);
      lo_q  <= lo_val;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.median_x2    = med_q;
  assign out_o.lower_middle = lo_q;

`ifndef SYNTHESIS
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= k) else $error("fill count exceeds window size");
  a_ptr_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    KW'(ptr_q) < k) else $error("oldest pointer outside window");
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (pend_q && out_valid_q && !out_o.ready))
    else $error("input stalled without a waiting result");
  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q) else $error("loaded result not shown");
`endif

endmodule

`default_nettype wire
